// ----- hw/rtl/ssrrip_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrrip_pkg
// Shared types and constants of the stream-aware RRIP replacement unit.
// ----------------------------------------------------------------------------
package ssrrip_pkg;

	localparam int SETS_DEF     = 2048;
	localparam int WAYS_DEF     = 16;
	localparam int SIG_BITS_DEF = 12;
	localparam int CORES_DEF    = 1;

	localparam logic [1:0] RRV_MAX   = 2'd3;
	localparam logic [1:0] SIG_MAX   = 2'd3;
	localparam logic [1:0] SIG_RESET = 2'd1;
	localparam logic [1:0] HOT_RESET = 2'd3;

	localparam int HASH_SH1 = 13;
	localparam int HASH_SH2 = 23;

	localparam int SET_IN_W = 11;
	localparam int WAY_IN_W = 4;
	localparam int CORE_IN_W = 3;
	localparam int S_TDATA_W = 152;
	localparam int M_TDATA_W = 8;
	localparam int PADDR_W   = 3;

	localparam logic [0:0] REG_HOT_THRESHOLD = 1'b0;
	localparam logic       OP_VICTIM = 1'b0;
	localparam logic       OP_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_CALC
	} ssrrip_state_t;

endpackage

// ----- hw/rtl/ship_stream_rrip_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// ship_stream_rrip_replacement_unit
// Stream-aware SRRIP replacement: victim select with aging, hit/miss update
// with PC-signature counters and per-core stride detection. After reset the
// unit sweeps both tables (max(SETS, 2**SIGNATURE_BITS) addresses) before it
// takes its first item. An item then passes through accept, row read and
// read-modify-write of the set row and signature counter; when SETS is below
// 2048 and is either one or not a power of two, the set is first reduced
// modulo SETS one bit per cycle between accept and row read. One item is in
// flight at a time, and the next is taken while the previous result waits in
// the output register.
// ----------------------------------------------------------------------------
module ship_stream_rrip_replacement_unit #(
	parameter int SETS           = ssrrip_pkg::SETS_DEF,
	parameter int WAYS           = ssrrip_pkg::WAYS_DEF,
	parameter int SIGNATURE_BITS = ssrrip_pkg::SIG_BITS_DEF,
	parameter int CORES          = ssrrip_pkg::CORES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// set_index[10:0], way_index[14:11], was_hit[15], pc[79:16],
	// address[143:80], core[146:144], zero[151:147]
	input  logic [ssrrip_pkg::S_TDATA_W-1:0]    s_tdata,
	// op[0]
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// victim_way[3:0], inserted_value[5:4], stream_seen[6], zero[7]
	output logic [ssrrip_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ssrrip_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = $clog2(WAYS);
	localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int SIG_N  = 1 << SIGNATURE_BITS;
	localparam int CLR_N  = (SETS > SIG_N) ? SETS : SIG_N;
	localparam int CLR_W  = $clog2(CLR_N + 1);
	localparam int SX     = (SET_W > ssrrip_pkg::SET_IN_W) ? SET_W : ssrrip_pkg::SET_IN_W;
	localparam int VX     = (WAY_W > ssrrip_pkg::WAY_IN_W) ? WAY_W : ssrrip_pkg::WAY_IN_W;
	localparam bit SET_POW2   = (SETS & (SETS - 1)) == 0;
	localparam bit SET_DIRECT = (SETS >= 2048) || (SET_POW2 && (SETS > 1));

	ssrrip_pkg::ssrrip_state_t state_q, state_d;

	logic [CLR_W-1:0]            clr_q;
	logic                        op_q;
	logic                        hit_q;
	logic [3:0]                  way_q;
	logic [63:0]                 addr_q;
	logic [CORE_W-1:0]           core_q;
	logic [SIGNATURE_BITS-1:0]   sig_q;
	logic [SET_W-1:0]            set_q;
	logic [ssrrip_pkg::SET_IN_W-1:0] set_raw_q;
	logic [3:0]                  mod_cnt_q;
	logic [1:0]                  thr_q;
	logic [WAYS-1:0][1:0]        rrv_rd_q;
	logic [1:0]                  sig_rd_q;
	logic [CORES-1:0][63:0]      last_addr_q;
	logic [CORES-1:0][63:0]      last_stride_q;
	logic                        out_valid_q;
	logic [ssrrip_pkg::M_TDATA_W-1:0] out_data_q;

	logic [WAYS-1:0][1:0] rrv_mem [SETS];
	logic [1:0]           sig_mem [SIG_N];

	logic                  accept;
	logic                  clr_active;
	logic                  rd_en;
	logic                  calc_done;
	logic                  mod_step;

	// input unpacking
	logic [ssrrip_pkg::SET_IN_W-1:0] in_set;
	logic [3:0]                      in_way;
	logic                            in_hit;
	logic [63:0]                     in_pc;
	logic [63:0]                     in_addr;
	logic [2:0]                      in_core;
	logic [63:0]                     pc_hash;
	logic [SX-1:0]                   set_wide;
	logic [3:0]                      core_red;

	assign in_set  = s_tdata[10:0];
	assign in_way  = s_tdata[14:11];
	assign in_hit  = s_tdata[15];
	assign in_pc   = s_tdata[79:16];
	assign in_addr = s_tdata[143:80];
	assign in_core = s_tdata[146:144];
	assign pc_hash = in_pc ^ (in_pc >> ssrrip_pkg::HASH_SH1) ^ (in_pc >> ssrrip_pkg::HASH_SH2);
	assign set_wide = SX'(in_set);

	always_comb begin
		core_red = {1'b0, in_core};
		for (int i = 0; i < 8; i++) begin
			if (core_red >= 4'(CORES)) begin
				core_red = core_red - 4'(CORES);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssrrip_pkg::ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ssrrip_pkg::ST_IDLE;
				end
			end
			ssrrip_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = SET_DIRECT ? ssrrip_pkg::ST_READ : ssrrip_pkg::ST_MOD;
				end
			end
			ssrrip_pkg::ST_MOD: begin
				if (mod_cnt_q == 4'd0) begin
					state_d = ssrrip_pkg::ST_READ;
				end
			end
			ssrrip_pkg::ST_READ: state_d = ssrrip_pkg::ST_CALC;
			ssrrip_pkg::ST_CALC: begin
				if (!out_valid_q || m_tready) begin
					state_d = ssrrip_pkg::ST_IDLE;
				end
			end
			default: state_d = ssrrip_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		clr_active = 1'b0;
		rd_en      = 1'b0;
		calc_done  = 1'b0;
		mod_step   = 1'b0;
		case (state_q)
			ssrrip_pkg::ST_CLEAR: clr_active = 1'b1;
			ssrrip_pkg::ST_IDLE:  s_tready = 1'b1;
			ssrrip_pkg::ST_MOD:   mod_step = 1'b1;
			ssrrip_pkg::ST_READ:  rd_en = 1'b1;
			ssrrip_pkg::ST_CALC:  calc_done = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// row evaluation
	logic                 any3, any2, any1;
	logic [1:0]           row_max;
	logic [1:0]           age_add;
	logic [WAYS-1:0][1:0] row_aged;
	logic [WAYS-1:0][1:0] row_upd;
	logic [WAY_W-1:0]     victim;
	logic [VX-1:0]        victim_wide;
	logic [VX-1:0]        way_wide;
	logic                 way_ok;
	logic [63:0]          stride;
	logic                 stream;
	logic [1:0]           ins_val;
	logic [1:0]           sig_inc;

	always_comb begin
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			any3 = any3 | (rrv_rd_q[w] == 2'd3);
			any2 = any2 | (rrv_rd_q[w] == 2'd2);
			any1 = any1 | (rrv_rd_q[w] == 2'd1);
		end
		row_max = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
		age_add = ssrrip_pkg::RRV_MAX - row_max;
		victim  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			row_aged[w] = rrv_rd_q[w] + age_add;
			if (rrv_rd_q[w] == row_max) begin
				victim = WAY_W'(w);
			end
		end
	end

	assign victim_wide = VX'(victim);
	assign way_wide    = VX'(way_q);
	assign way_ok      = int'(way_q) < WAYS;

	assign stride = addr_q - last_addr_q[core_q];
	assign stream = !op_q ? 1'b0 :
		(!hit_q && (last_stride_q[core_q] != 64'd0) && (stride == last_stride_q[core_q]));

	always_comb begin
		if (hit_q) begin
			ins_val = 2'd0;
		end else if (stream) begin
			ins_val = ssrrip_pkg::RRV_MAX;
		end else if (sig_rd_q >= thr_q) begin
			ins_val = 2'd0;
		end else begin
			ins_val = ssrrip_pkg::RRV_MAX;
		end
		row_upd = rrv_rd_q;
		if (way_ok) begin
			row_upd[way_wide[WAY_W-1:0]] = ins_val;
		end
		sig_inc = (sig_rd_q < ssrrip_pkg::SIG_MAX) ? sig_rd_q + 2'd1 : sig_rd_q;
	end

	// memory ports
	logic                 rrv_we;
	logic [SET_W-1:0]     rrv_wa;
	logic [WAYS-1:0][1:0] rrv_wd;
	logic                 sig_we;
	logic [SIGNATURE_BITS-1:0] sig_wa;
	logic [1:0]           sig_wd;

	always_comb begin
		if (clr_active) begin
			rrv_we = clr_q < CLR_W'(SETS);
			rrv_wa = clr_q[SET_W-1:0];
			rrv_wd = {WAYS{ssrrip_pkg::RRV_MAX}};
			sig_we = clr_q < CLR_W'(SIG_N);
			sig_wa = clr_q[SIGNATURE_BITS-1:0];
			sig_wd = ssrrip_pkg::SIG_RESET;
		end else begin
			rrv_we = calc_done;
			rrv_wa = set_q;
			rrv_wd = (op_q == ssrrip_pkg::OP_UPDATE) ? row_upd : row_aged;
			sig_we = calc_done && (op_q == ssrrip_pkg::OP_UPDATE) && hit_q;
			sig_wa = sig_q;
			sig_wd = sig_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (rrv_we) begin
			rrv_mem[rrv_wa] <= rrv_wd;
		end
		if (rd_en) begin
			rrv_rd_q <= rrv_mem[set_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[sig_wa] <= sig_wd;
		end
		if (rd_en) begin
			sig_rd_q <= sig_mem[sig_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ssrrip_pkg::ST_CLEAR;
			clr_q         <= '0;
			thr_q         <= ssrrip_pkg::HOT_RESET;
			last_addr_q   <= '0;
			last_stride_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_active) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (psel && penable && pwrite && pready
				&& (paddr[2] == ssrrip_pkg::REG_HOT_THRESHOLD)) begin
				thr_q <= pwdata[1:0];
			end
			if (calc_done && (op_q == ssrrip_pkg::OP_UPDATE) && !hit_q) begin
				last_addr_q[core_q]   <= addr_q;
				last_stride_q[core_q] <= stride;
			end
			if (calc_done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload
	logic [SET_W:0] mod_rem;

	assign mod_rem = ({set_q, set_raw_q[mod_cnt_q]} >= (SET_W + 1)'(SETS))
		? {set_q, set_raw_q[mod_cnt_q]} - (SET_W + 1)'(SETS)
		: {set_q, set_raw_q[mod_cnt_q]};

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= s_tuser[0];
			hit_q     <= in_hit;
			way_q     <= in_way;
			addr_q    <= in_addr;
			core_q    <= core_red[CORE_W-1:0];
			sig_q     <= pc_hash[SIGNATURE_BITS-1:0];
			set_raw_q <= in_set;
			mod_cnt_q <= 4'(ssrrip_pkg::SET_IN_W - 1);
			set_q     <= SET_DIRECT ? set_wide[SET_W-1:0] : '0;
		end else if (mod_step) begin
			set_q     <= mod_rem[SET_W-1:0];
			mod_cnt_q <= mod_cnt_q - 4'd1;
		end
		if (calc_done) begin
			if (op_q == ssrrip_pkg::OP_VICTIM) begin
				out_data_q <= {4'd0, victim_wide[3:0]};
			end else begin
				out_data_q <= {1'b0, stream, ins_val, 4'd0};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == ssrrip_pkg::REG_HOT_THRESHOLD) ? {30'd0, thr_q} : 32'd0;

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ssrrip_pkg::ST_READ || state_q == ssrrip_pkg::ST_MOD))
		else $error("accepted item did not start a table read");

	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ssrrip_pkg::ST_CALC)
		else $error("result raised outside the update step");

	a_stream_on_miss_only: assert property (@(posedge clk) disable iff (!arst_n)
		(calc_done && (hit_q || op_q == ssrrip_pkg::OP_VICTIM)) |=> !out_data_q[6])
		else $error("stream flagged on a hit or a victim request");

endmodule
